// File: sv/blm_pkg.sv
// shared types, codes and saturating fixed-point helpers of the line minimizer
package blm_pkg;

  typedef logic signed [63:0] fix_t;

  localparam fix_t FIX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fix_t FIX_MIN = 64'sh8000_0000_0000_0000;

  // golden ratio constant 0.3819660 as unsigned Q0.32
  localparam fix_t CGOLD = 64'sd1640531478;

  // input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_VALUE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_EVAL = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  // configuration register indexes
  localparam logic CFG_TOL = 1'b0;
  localparam logic CFG_LIM = 1'b1;

  typedef struct packed {
    logic       cmd;
    fix_t       bracket_first;
    fix_t       initial_guess;
    fix_t       bracket_second;
    fix_t       func_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    fix_t        point;
    fix_t        min_value;
    logic [15:0] iterations;
    logic [15:0] evaluations;
  } out_item_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_STEP
  } phase_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LIMIT,
    S_M_TOL,
    S_CONV,
    S_M_R,
    S_M_Q,
    S_M_P1,
    S_M_P2,
    S_QFIX,
    S_M_M1,
    S_M_M2,
    S_M_M3,
    S_TEST,
    S_DIV,
    S_UCHK,
    S_GE,
    S_M_G,
    S_FINISH,
    S_OUT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_START,
    OP_FIRST,
    OP_TAKE,
    OP_FAIL,
    OP_ITER,
    OP_M_TOL,
    OP_CONV,
    OP_TOL2,
    OP_M_R,
    OP_M_Q,
    OP_M_P1,
    OP_M_P2,
    OP_QFIX,
    OP_M_M1,
    OP_M_M2,
    OP_M_M3,
    OP_DIV,
    OP_UCHK,
    OP_GE,
    OP_M_G,
    OP_FINISH,
    OP_LOAD_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic limit_hit;
    logic conv;
    logic e_big;
    logic use_golden;
    logic mul_done;
    logic div_done;
  } dp_stat_t;

  // saturating add
  function automatic fix_t sadd(input fix_t a, input fix_t b);
    fix_t r;
    r = a + b;
    if (!a[63] && !b[63] && r[63]) return FIX_MAX;
    if (a[63] && b[63] && !r[63]) return FIX_MIN;
    return r;
  endfunction

  // saturating subtract
  function automatic fix_t ssub(input fix_t a, input fix_t b);
    fix_t r;
    r = a - b;
    if (!a[63] && b[63] && r[63]) return FIX_MAX;
    if (a[63] && !b[63] && !r[63]) return FIX_MIN;
    return r;
  endfunction

  function automatic fix_t sabs(input fix_t a);
    if (a == FIX_MIN) return FIX_MAX;
    return a[63] ? -a : a;
  endfunction

  function automatic fix_t sneg(input fix_t a);
    if (a == FIX_MIN) return FIX_MAX;
    return -a;
  endfunction

  // halving toward minus infinity
  function automatic fix_t shalf(input fix_t a);
    return a >>> 1;
  endfunction

  // exact floor midpoint
  function automatic fix_t mean(input fix_t a, input fix_t b);
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] m;
    ua = a ^ 64'h8000_0000_0000_0000;
    ub = b ^ 64'h8000_0000_0000_0000;
    m  = (ua >> 1) + (ub >> 1) + {63'd0, ua[0] & ub[0]};
    return fix_t'(m ^ 64'h8000_0000_0000_0000);
  endfunction

  function automatic logic [63:0] mag(input fix_t a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

endpackage

// File: sv/blm_mul.sv
// multi-cycle saturating signed fixed-point multiplier, one 32x32 partial product a cycle
module blm_mul #(
  parameter int FRAC_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  blm_pkg::fix_t  a_i,
  input  blm_pkg::fix_t  b_i,
  input  logic           sh32_i,
  output logic           busy_o,
  output logic           done_o,
  output blm_pkg::fix_t  res_o
);

  logic         busy_q, busy_d;
  logic [2:0]   cnt_q, cnt_d;
  logic [63:0]  ma_q, mb_q;
  logic         neg_q, sh_q;
  logic [127:0] acc_q;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] ppx, shifted;
  logic [62:0]  m;

  // partial product select
  always_comb begin
    pa = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
    pb = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
    pp = 64'(pa) * 64'(pb);
    case (cnt_q[1:0])
      2'd0:    ppx = {64'd0, pp};
      2'd3:    ppx = {pp, 64'd0};
      default: ppx = {32'd0, pp, 32'd0};
    endcase
  end

  // control
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_o = busy_q && (cnt_q == 3'd4);
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = 3'd0;
    end else if (busy_q) begin
      if (done_o) busy_d = 1'b0;
      else cnt_d = cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      ma_q  <= blm_pkg::mag(a_i);
      mb_q  <= blm_pkg::mag(b_i);
      neg_q <= a_i[63] ^ b_i[63];
      sh_q  <= sh32_i;
      acc_q <= '0;
    end else if (busy_q && !done_o) begin
      acc_q <= acc_q + ppx;
    end
  end

  // shift, saturate, sign
  always_comb begin
    shifted = sh_q ? (acc_q >> 32) : (acc_q >> FRAC_BITS);
    m       = (|shifted[127:63]) ? {63{1'b1}} : shifted[62:0];
    res_o   = neg_q ? -blm_pkg::fix_t'({1'b0, m}) : blm_pkg::fix_t'({1'b0, m});
  end

  assign busy_o = busy_q;

endmodule

// File: sv/blm_div.sv
// restoring fixed-point divider, one quotient bit a cycle, saturating
module blm_div #(
  parameter int FRAC_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  blm_pkg::fix_t  p_i,
  input  blm_pkg::fix_t  q_i,
  output logic           done_o,
  output blm_pkg::fix_t  res_o
);

  logic         busy_q, busy_d;
  logic [7:0]   cnt_q, cnt_d;
  logic [127:0] dvd_q;
  logic [63:0]  dsr_q, rem_q, quo_q;
  logic         ovf_q, neg_q, psign_q, dz_q, nz_q;
  logic [64:0]  rem_sh, rem_sub;
  logic         qb;
  logic [62:0]  m;

  assign done_o = busy_q && cnt_q[7];

  // control
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = 8'd0;
    end else if (busy_q) begin
      if (done_o) busy_d = 1'b0;
      else cnt_d = cnt_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 8'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // one restoring step
  always_comb begin
    rem_sh  = {rem_q, dvd_q[127]};
    rem_sub = rem_sh - {1'b0, dsr_q};
    qb      = (rem_sh >= {1'b0, dsr_q});
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      dvd_q   <= {64'd0, blm_pkg::mag(p_i)} << FRAC_BITS;
      dsr_q   <= blm_pkg::mag(q_i);
      rem_q   <= '0;
      quo_q   <= '0;
      ovf_q   <= 1'b0;
      neg_q   <= p_i[63] ^ q_i[63];
      psign_q <= p_i[63];
      dz_q    <= (q_i == '0);
      nz_q    <= (p_i == '0);
    end else if (busy_q && !done_o) begin
      rem_q <= qb ? rem_sub[63:0] : rem_sh[63:0];
      ovf_q <= ovf_q | quo_q[63];
      quo_q <= {quo_q[62:0], qb};
      dvd_q <= dvd_q << 1;
    end
  end

  // result with zero divisor handling
  always_comb begin
    m = (ovf_q || quo_q[63]) ? {63{1'b1}} : quo_q[62:0];
    if (dz_q) begin
      if (nz_q) res_o = '0;
      else res_o = psign_q ? -blm_pkg::FIX_MAX : blm_pkg::FIX_MAX;
    end else begin
      res_o = neg_q ? -blm_pkg::fix_t'({1'b0, m}) : blm_pkg::fix_t'({1'b0, m});
    end
  end

endmodule

// File: sv/blm_dp.sv
// datapath: search state, configuration registers, arithmetic units and result register
module blm_dp #(
  parameter int FRAC_BITS  = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  blm_pkg::dp_cmd_t   cmd_i,
  output blm_pkg::dp_stat_t  stat_o,
  input  blm_pkg::in_item_t  in_item_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output blm_pkg::out_item_t out_item_o
);

  localparam blm_pkg::fix_t ZEPS = 64'((28147 >> (48 - FRAC_BITS)) + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  blm_pkg::fix_t a_q, b_q, x_q, w_q, v_q, fx_q, fw_q, fv_q;
  blm_pkg::fix_t dd_q, e_q, u_q, dn_q, olde_q;
  blm_pkg::fix_t xm_q, tol1_q, tol2_q, r_q, q_q, p_q, m1_q, m2_q, m3_q;
  logic [COUNT_BITS-1:0] iter_q, eval_q, iter_inc, eval_inc;
  logic [31:0] tol_q;
  logic [15:0] lim_q;
  blm_pkg::out_item_t res_q, out_q;

  blm_pkg::fix_t x_m_w, x_m_v, a_m_x, b_m_x, fx_m_fv, fx_m_fw, xm_m_x;
  blm_pkg::fix_t mul_a, mul_b, mul_res, div_res;
  logic mul_op, mul_start, mul_busy, mul_done, sh32, div_start, div_done;
  blm_pkg::fix_t tol2c, qa, qb, uu, ustep, fu;
  logic [31:0] iter_w, eval_w, iter_inc_w, eval_inc_w;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 32'd129;
      lim_q <= 16'd100;
    end else if (cfg_we_i) begin
      if (cfg_index_i == blm_pkg::CFG_TOL) tol_q <= cfg_data_i;
      else lim_q <= cfg_data_i[15:0];
    end
  end

  // differences and counters
  always_comb begin
    x_m_w    = blm_pkg::ssub(x_q, w_q);
    x_m_v    = blm_pkg::ssub(x_q, v_q);
    a_m_x    = blm_pkg::ssub(a_q, x_q);
    b_m_x    = blm_pkg::ssub(b_q, x_q);
    fx_m_fv  = blm_pkg::ssub(fx_q, fv_q);
    fx_m_fw  = blm_pkg::ssub(fx_q, fw_q);
    xm_m_x   = blm_pkg::ssub(xm_q, x_q);
    iter_inc = (iter_q == CNT_MAX) ? iter_q : iter_q + 1'b1;
    eval_inc = (eval_q == CNT_MAX) ? eval_q : eval_q + 1'b1;
    iter_w     = 32'(iter_q);
    eval_w     = 32'(eval_q);
    iter_inc_w = 32'(iter_inc);
    eval_inc_w = 32'(eval_inc);
  end

  // multiplier operand select
  always_comb begin
    mul_op = 1'b1;
    sh32   = 1'b0;
    mul_a  = q_q;
    mul_b  = r_q;
    case (cmd_i.op)
      blm_pkg::OP_M_TOL: begin
        mul_a = 64'(tol_q);
        mul_b = x_q;
        sh32  = 1'b1;
      end
      blm_pkg::OP_M_R: begin
        mul_a = x_m_w;
        mul_b = fx_m_fv;
      end
      blm_pkg::OP_M_Q: begin
        mul_a = x_m_v;
        mul_b = fx_m_fw;
      end
      blm_pkg::OP_M_P1: begin
        mul_a = x_m_v;
        mul_b = q_q;
      end
      blm_pkg::OP_M_P2: begin
        mul_a = x_m_w;
        mul_b = r_q;
      end
      blm_pkg::OP_M_M1: begin
        mul_a = blm_pkg::shalf(q_q);
        mul_b = olde_q;
      end
      blm_pkg::OP_M_M2: begin
        mul_a = q_q;
        mul_b = a_m_x;
      end
      blm_pkg::OP_M_M3: begin
        mul_a = q_q;
        mul_b = b_m_x;
      end
      blm_pkg::OP_M_G: begin
        mul_a = e_q;
        mul_b = blm_pkg::CGOLD;
        sh32  = 1'b1;
      end
      default: mul_op = 1'b0;
    endcase
    mul_start = mul_op && !mul_busy;
    div_start = (cmd_i.op == blm_pkg::OP_DIV);
  end

  blm_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sh32_i  (sh32),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  blm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .p_i     (p_q),
    .q_i     (q_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  // status and step helpers
  always_comb begin
    tol2c = blm_pkg::sadd(tol1_q, tol1_q);
    qa    = blm_pkg::ssub(q_q, r_q);
    qb    = blm_pkg::sadd(qa, qa);
    uu    = blm_pkg::sadd(x_q, dn_q);
    ustep = (blm_pkg::sabs(dn_q) >= tol1_q) ? dn_q : (dn_q[63] ? -tol1_q : tol1_q);
    fu    = in_item_i.func_value;
    stat_o.limit_hit = (iter_w >= 32'(lim_q)) || (iter_q == CNT_MAX);
    stat_o.conv = blm_pkg::sabs(blm_pkg::ssub(x_q, xm_q)) <=
                  blm_pkg::ssub(tol2c, blm_pkg::shalf(blm_pkg::ssub(b_q, a_q)));
    stat_o.e_big = blm_pkg::sabs(e_q) > tol1_q;
    stat_o.use_golden = (blm_pkg::sabs(p_q) >= blm_pkg::sabs(m1_q)) ||
                        (p_q <= m2_q) || (p_q >= m3_q);
    stat_o.mul_done = mul_done;
    stat_o.div_done = div_done;
  end

  // search state updates
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      blm_pkg::OP_START: begin
        a_q    <= (in_item_i.bracket_first < in_item_i.bracket_second) ?
                  in_item_i.bracket_first : in_item_i.bracket_second;
        b_q    <= (in_item_i.bracket_first > in_item_i.bracket_second) ?
                  in_item_i.bracket_first : in_item_i.bracket_second;
        x_q    <= in_item_i.initial_guess;
        w_q    <= in_item_i.initial_guess;
        v_q    <= in_item_i.initial_guess;
        fx_q   <= '0;
        fw_q   <= '0;
        fv_q   <= '0;
        dd_q   <= '0;
        e_q    <= '0;
        u_q    <= in_item_i.initial_guess;
        iter_q <= '0;
        eval_q <= COUNT_BITS'(1);
        res_q  <= '{blm_pkg::ST_EVAL, in_item_i.initial_guess, '0, 16'd0, 16'd1};
      end
      blm_pkg::OP_FIRST: begin
        fx_q <= fu;
        fw_q <= fu;
        fv_q <= fu;
      end
      blm_pkg::OP_TAKE: begin
        if (fu <= fx_q) begin
          if (u_q >= x_q) a_q <= x_q;
          else b_q <= x_q;
          v_q  <= w_q;
          w_q  <= x_q;
          x_q  <= u_q;
          fv_q <= fw_q;
          fw_q <= fx_q;
          fx_q <= fu;
        end else begin
          if (u_q < x_q) a_q <= u_q;
          else b_q <= u_q;
          if (fu <= fw_q || w_q == x_q) begin
            v_q  <= w_q;
            w_q  <= u_q;
            fv_q <= fw_q;
            fw_q <= fu;
          end else if (fu <= fv_q || v_q == x_q || v_q == w_q) begin
            v_q  <= u_q;
            fv_q <= fu;
          end
        end
      end
      blm_pkg::OP_FAIL: begin
        iter_q <= iter_inc;
        res_q  <= '{blm_pkg::ST_FAIL, x_q, fx_q, iter_inc_w[15:0], eval_w[15:0]};
      end
      blm_pkg::OP_ITER: begin
        iter_q <= iter_inc;
        xm_q   <= blm_pkg::mean(a_q, b_q);
      end
      blm_pkg::OP_M_TOL: if (mul_done) tol1_q <= blm_pkg::sadd(blm_pkg::sabs(mul_res), ZEPS);
      blm_pkg::OP_CONV:
        res_q <= '{blm_pkg::ST_CONV, x_q, fx_q, iter_w[15:0], eval_w[15:0]};
      blm_pkg::OP_TOL2: tol2_q <= tol2c;
      blm_pkg::OP_M_R:  if (mul_done) r_q <= mul_res;
      blm_pkg::OP_M_Q:  if (mul_done) q_q <= mul_res;
      blm_pkg::OP_M_P1: if (mul_done) p_q <= mul_res;
      blm_pkg::OP_M_P2: if (mul_done) p_q <= blm_pkg::ssub(p_q, mul_res);
      blm_pkg::OP_QFIX: begin
        if (!qb[63] && qb != '0) p_q <= blm_pkg::sneg(p_q);
        q_q    <= blm_pkg::sabs(qb);
        olde_q <= e_q;
        e_q    <= dd_q;
      end
      blm_pkg::OP_M_M1: if (mul_done) m1_q <= mul_res;
      blm_pkg::OP_M_M2: if (mul_done) m2_q <= mul_res;
      blm_pkg::OP_M_M3: if (mul_done) m3_q <= mul_res;
      blm_pkg::OP_DIV:  if (div_done) dn_q <= div_res;
      blm_pkg::OP_UCHK: begin
        if (blm_pkg::ssub(uu, a_q) < tol2_q || blm_pkg::ssub(b_q, uu) < tol2_q)
          dn_q <= xm_m_x[63] ? -tol1_q : tol1_q;
      end
      blm_pkg::OP_GE: e_q <= (x_q >= xm_q) ? a_m_x : b_m_x;
      blm_pkg::OP_M_G: if (mul_done) dn_q <= mul_res;
      blm_pkg::OP_FINISH: begin
        dd_q   <= dn_q;
        u_q    <= blm_pkg::sadd(x_q, ustep);
        eval_q <= eval_inc;
        res_q  <= '{blm_pkg::ST_EVAL, blm_pkg::sadd(x_q, ustep), '0,
                    iter_w[15:0], eval_inc_w[15:0]};
      end
      blm_pkg::OP_LOAD_OUT: out_q <= res_q;
      default: ;
    endcase
  end

  assign out_item_o = out_q;

endmodule

// File: sv/blm_ctrl.sv
// controller: search phase, step sequencing and channel handshakes
module blm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_cmd_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output blm_pkg::dp_cmd_t   cmd_o,
  input  blm_pkg::dp_stat_t  stat_i
);

  blm_pkg::state_e state_q, state_d;
  blm_pkg::phase_e phase_q, phase_d;
  logic            ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= blm_pkg::S_IDLE;
      phase_q <= blm_pkg::PH_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      ov_q    <= ov_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    ov_d       = ov_q && out_stall_i;
    in_stall_o = 1'b1;
    cmd_o.op   = blm_pkg::OP_NONE;
    unique case (state_q)
      blm_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (in_cmd_i == blm_pkg::CMD_START) begin
            cmd_o.op = blm_pkg::OP_START;
            phase_d  = blm_pkg::PH_FIRST;
            state_d  = blm_pkg::S_OUT;
          end else if (phase_q == blm_pkg::PH_FIRST) begin
            cmd_o.op = blm_pkg::OP_FIRST;
            state_d  = blm_pkg::S_LIMIT;
          end else if (phase_q == blm_pkg::PH_STEP) begin
            cmd_o.op = blm_pkg::OP_TAKE;
            state_d  = blm_pkg::S_LIMIT;
          end
        end
      end
      blm_pkg::S_LIMIT: begin
        if (stat_i.limit_hit) begin
          cmd_o.op = blm_pkg::OP_FAIL;
          phase_d  = blm_pkg::PH_IDLE;
          state_d  = blm_pkg::S_OUT;
        end else begin
          cmd_o.op = blm_pkg::OP_ITER;
          state_d  = blm_pkg::S_M_TOL;
        end
      end
      blm_pkg::S_M_TOL: begin
        cmd_o.op = blm_pkg::OP_M_TOL;
        if (stat_i.mul_done) state_d = blm_pkg::S_CONV;
      end
      blm_pkg::S_CONV: begin
        if (stat_i.conv) begin
          cmd_o.op = blm_pkg::OP_CONV;
          phase_d  = blm_pkg::PH_IDLE;
          state_d  = blm_pkg::S_OUT;
        end else begin
          cmd_o.op = blm_pkg::OP_TOL2;
          state_d  = stat_i.e_big ? blm_pkg::S_M_R : blm_pkg::S_GE;
        end
      end
      blm_pkg::S_M_R: begin
        cmd_o.op = blm_pkg::OP_M_R;
        if (stat_i.mul_done) state_d = blm_pkg::S_M_Q;
      end
      blm_pkg::S_M_Q: begin
        cmd_o.op = blm_pkg::OP_M_Q;
        if (stat_i.mul_done) state_d = blm_pkg::S_M_P1;
      end
      blm_pkg::S_M_P1: begin
        cmd_o.op = blm_pkg::OP_M_P1;
        if (stat_i.mul_done) state_d = blm_pkg::S_M_P2;
      end
      blm_pkg::S_M_P2: begin
        cmd_o.op = blm_pkg::OP_M_P2;
        if (stat_i.mul_done) state_d = blm_pkg::S_QFIX;
      end
      blm_pkg::S_QFIX: begin
        cmd_o.op = blm_pkg::OP_QFIX;
        state_d  = blm_pkg::S_M_M1;
      end
      blm_pkg::S_M_M1: begin
        cmd_o.op = blm_pkg::OP_M_M1;
        if (stat_i.mul_done) state_d = blm_pkg::S_M_M2;
      end
      blm_pkg::S_M_M2: begin
        cmd_o.op = blm_pkg::OP_M_M2;
        if (stat_i.mul_done) state_d = blm_pkg::S_M_M3;
      end
      blm_pkg::S_M_M3: begin
        cmd_o.op = blm_pkg::OP_M_M3;
        if (stat_i.mul_done) state_d = blm_pkg::S_TEST;
      end
      blm_pkg::S_TEST: begin
        state_d = stat_i.use_golden ? blm_pkg::S_GE : blm_pkg::S_DIV;
      end
      blm_pkg::S_DIV: begin
        cmd_o.op = blm_pkg::OP_DIV;
        if (stat_i.div_done) state_d = blm_pkg::S_UCHK;
      end
      blm_pkg::S_UCHK: begin
        cmd_o.op = blm_pkg::OP_UCHK;
        state_d  = blm_pkg::S_FINISH;
      end
      blm_pkg::S_GE: begin
        cmd_o.op = blm_pkg::OP_GE;
        state_d  = blm_pkg::S_M_G;
      end
      blm_pkg::S_M_G: begin
        cmd_o.op = blm_pkg::OP_M_G;
        if (stat_i.mul_done) state_d = blm_pkg::S_FINISH;
      end
      blm_pkg::S_FINISH: begin
        cmd_o.op = blm_pkg::OP_FINISH;
        phase_d  = blm_pkg::PH_STEP;
        state_d  = blm_pkg::S_OUT;
      end
      blm_pkg::S_OUT: begin
        if (!ov_q || !out_stall_i) begin
          cmd_o.op = blm_pkg::OP_LOAD_OUT;
          ov_d     = 1'b1;
          state_d  = blm_pkg::S_IDLE;
        end
      end
      default: state_d = blm_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;

endmodule

// File: sv/brent_line_minimizer_unit.sv
// top level of the Brent line minimizer
//
// A start beat (cmd 0) carries the two bracket ends and the first guess; the
// block answers with a request to evaluate f at that guess. Each value beat
// (cmd 1) carries f at the point last requested; the block answers with the
// next point to evaluate, a converged result or an iteration limit failure.
// A value beat while no search runs is dropped without a result.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// Configuration writes (tolerance, iteration limit) use cfg_valid_i/cfg_ready_o
// and are always taken.
// A value beat's work depends on its path: the iteration limit, convergence,
// a golden-section step or a parabolic step. Every path past the limit test
// uses the shared multiplier, up to nine times per value beat, and a parabolic
// step also uses the bit-serial divider.
// One item is worked on at a time; the next is accepted once the result sits
// in the output register, even while the receiver still stalls it.
// Reset clears the search to idle and the registers to tolerance 129 and
// iteration limit 100.
module brent_line_minimizer_unit #(
  parameter int FRAC_BITS  = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  blm_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output blm_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  blm_pkg::dp_cmd_t  cmd;
  blm_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  // sequencing
  blm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_item_i.cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // arithmetic and state
  blm_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: tb/brent_line_minimizer_unit_tb.sv
// testbench of the brent line minimizer unit: bit-true prediction and scoreboard
`timescale 1ns / 100ps

module brent_line_minimizer_unit_tb;

  localparam int            CLK_HALF   = 6;
  localparam int            DRAIN_WAIT = 250;
  localparam int            HOLD_LEN   = 400;
  localparam int unsigned   CYCLE_MAX  = 3000000;
  localparam blm_pkg::fix_t TOP_VAL    = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam blm_pkg::fix_t BOT_VAL    = 64'sh8000_0000_0000_0000;

  // predictor of the minimizer plus the queue of expected results
  class line_search_scoreboard;
    logic [31:0]        tol;
    logic [15:0]        lim;
    blm_pkg::fix_t      lo_end, hi_end, xb, wp, vp, fx, fw, fv, d_now, e_prev, pend;
    logic [15:0]        iters, evals;
    blm_pkg::phase_e    ph;
    blm_pkg::out_item_t waiting[$];
    int                 errors;

    function new();
      tol = 129; lim = 100;
      lo_end = 0; hi_end = 0; xb = 0; wp = 0; vp = 0; fx = 0; fw = 0; fv = 0;
      d_now = 0; e_prev = 0; pend = 0; iters = 0; evals = 0; ph = blm_pkg::PH_IDLE;
      errors = 0;
    endfunction

    function void report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void set_register(logic idx, logic [31:0] data);
      if (idx == blm_pkg::CFG_TOL) tol = data;
      else lim = data[15:0];
    endfunction

    // saturating fixed-point arithmetic
    function blm_pkg::fix_t add_s(blm_pkg::fix_t a, blm_pkg::fix_t b);
      blm_pkg::fix_t r;
      r = a + b;
      if (!a[63] && !b[63] && r[63]) return TOP_VAL;
      if (a[63] && b[63] && !r[63]) return BOT_VAL;
      return r;
    endfunction

    function blm_pkg::fix_t sub_s(blm_pkg::fix_t a, blm_pkg::fix_t b);
      blm_pkg::fix_t r;
      r = a - b;
      if (!a[63] && b[63] && r[63]) return TOP_VAL;
      if (a[63] && !b[63] && !r[63]) return BOT_VAL;
      return r;
    endfunction

    function blm_pkg::fix_t abs_s(blm_pkg::fix_t a);
      if (a == BOT_VAL) return TOP_VAL;
      return a < 0 ? -a : a;
    endfunction

    function blm_pkg::fix_t neg_s(blm_pkg::fix_t a);
      if (a == BOT_VAL) return TOP_VAL;
      return -a;
    endfunction

    function blm_pkg::fix_t half_floor(blm_pkg::fix_t a);
      return a >>> 1;
    endfunction

    function blm_pkg::fix_t mid_floor(blm_pkg::fix_t a, blm_pkg::fix_t b);
      return (a >>> 1) + (b >>> 1) + blm_pkg::fix_t'(a[0] & b[0]);
    endfunction

    function logic [63:0] magn(blm_pkg::fix_t a);
      logic [63:0] u;
      u = a;
      return a[63] ? -u : u;
    endfunction

    function blm_pkg::fix_t sign_clip(logic [63:0] m, bit neg);
      blm_pkg::fix_t r;
      if (m > 64'h7FFF_FFFF_FFFF_FFFF) m = 64'h7FFF_FFFF_FFFF_FFFF;
      r = blm_pkg::fix_t'(m);
      return neg ? -r : r;
    endfunction

    function logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
      logic [127:0] p;
      logic [127:0] s;
      p = {64'd0, a} * {64'd0, b};
      s = p >> sh;
      if ((p >> (64 + sh)) != 0) return '1;
      return s[63:0];
    endfunction

    function blm_pkg::fix_t fmul(blm_pkg::fix_t a, blm_pkg::fix_t b);
      return sign_clip(mul_shift(magn(a), magn(b), 32), a[63] != b[63]);
    endfunction

    function blm_pkg::fix_t qdiv(blm_pkg::fix_t p, blm_pkg::fix_t q);
      logic [63:0]  n, dd;
      logic [127:0] num, quo;
      n  = magn(p);
      dd = magn(q);
      if (dd == 0) return n == 0 ? blm_pkg::fix_t'(0) : (p[63] ? -TOP_VAL : TOP_VAL);
      num = {64'd0, n} << 32;
      quo = num / {64'd0, dd};
      if (quo[127:64] != 0) quo[63:0] = '1;
      return sign_clip(quo[63:0], p[63] != q[63]);
    endfunction

    function blm_pkg::fix_t golden_step(blm_pkg::fix_t x, blm_pkg::fix_t xm);
      e_prev = (x >= xm) ? sub_s(lo_end, x) : sub_s(hi_end, x);
      return fmul(e_prev, blm_pkg::CGOLD);
    endfunction

    function blm_pkg::out_item_t make_result(logic [1:0] st, blm_pkg::fix_t pt,
                                             blm_pkg::fix_t mv);
      blm_pkg::out_item_t o;
      o.status = st; o.point = pt; o.min_value = mv;
      o.iterations = iters; o.evaluations = evals;
      return o;
    endfunction

    // one iteration: limit test, convergence test, then the next trial point
    function blm_pkg::out_item_t iterate();
      blm_pkg::fix_t xm, tol1, tol2, d, u, r, q, p, old_e;
      if (iters >= lim || iters == 16'hFFFF) begin
        if (iters != 16'hFFFF) iters++;
        ph = blm_pkg::PH_IDLE;
        return make_result(blm_pkg::ST_FAIL, xb, fx);
      end
      iters++;
      xm   = mid_floor(lo_end, hi_end);
      tol1 = add_s(sign_clip(mul_shift({32'd0, tol}, magn(xb), 32), 1'b0), 64'sd1);
      tol2 = add_s(tol1, tol1);
      if (abs_s(sub_s(xb, xm)) <= sub_s(tol2, half_floor(sub_s(hi_end, lo_end)))) begin
        ph = blm_pkg::PH_IDLE;
        return make_result(blm_pkg::ST_CONV, xb, fx);
      end
      if (abs_s(e_prev) > tol1) begin
        r = fmul(sub_s(xb, wp), sub_s(fx, fv));
        q = fmul(sub_s(xb, vp), sub_s(fx, fw));
        p = sub_s(fmul(sub_s(xb, vp), q), fmul(sub_s(xb, wp), r));
        old_e = e_prev;
        q = sub_s(q, r);
        q = add_s(q, q);
        if (q > 0) p = neg_s(p);
        q = abs_s(q);
        e_prev = d_now;
        if (abs_s(p) >= abs_s(fmul(half_floor(q), old_e)) ||
            p <= fmul(q, sub_s(lo_end, xb)) || p >= fmul(q, sub_s(hi_end, xb))) begin
          d = golden_step(xb, xm);
        end else begin
          d = qdiv(p, q);
          u = add_s(xb, d);
          if (sub_s(u, lo_end) < tol2 || sub_s(hi_end, u) < tol2)
            d = (sub_s(xm, xb) >= 0) ? tol1 : -tol1;
        end
      end else begin
        d = golden_step(xb, xm);
      end
      d_now = d;
      u = (abs_s(d) >= tol1) ? add_s(xb, d) : add_s(xb, (d >= 0) ? tol1 : -tol1);
      pend = u;
      if (evals != 16'hFFFF) evals++;
      ph = blm_pkg::PH_STEP;
      return make_result(blm_pkg::ST_EVAL, u, 0);
    endfunction

    // bracket and x/w/v update from the value at the pending point
    function void absorb_value(blm_pkg::fix_t fu);
      blm_pkg::fix_t u, x;
      u = pend;
      x = xb;
      if (fu <= fx) begin
        if (u >= x) lo_end = x; else hi_end = x;
        vp = wp; wp = x; xb = u;
        fv = fw; fw = fx; fx = fu;
      end else begin
        if (u < x) lo_end = u; else hi_end = u;
        if (fu <= fw || wp == x) begin
          vp = wp; wp = u; fv = fw; fw = fu;
        end else if (fu <= fv || vp == x || vp == wp) begin
          vp = u; fv = fu;
        end
      end
    endfunction

    function void note_input(blm_pkg::in_item_t it);
      if (it.cmd == blm_pkg::CMD_START) begin
        lo_end = (it.bracket_first < it.bracket_second) ? it.bracket_first
                                                        : it.bracket_second;
        hi_end = (it.bracket_first > it.bracket_second) ? it.bracket_first
                                                        : it.bracket_second;
        xb = it.initial_guess; wp = xb; vp = xb;
        fx = 0; fw = 0; fv = 0; d_now = 0; e_prev = 0;
        pend = xb; iters = 0; evals = 1; ph = blm_pkg::PH_FIRST;
        waiting.push_back(make_result(blm_pkg::ST_EVAL, xb, 0));
      end else if (ph == blm_pkg::PH_FIRST) begin
        fx = it.func_value; fw = fx; fv = fx;
        waiting.push_back(iterate());
      end else if (ph == blm_pkg::PH_STEP) begin
        absorb_value(it.func_value);
        waiting.push_back(iterate());
      end
    endfunction

    function void check_result(blm_pkg::out_item_t got);
      blm_pkg::out_item_t want;
      if (waiting.size() == 0) begin
        report("result with no expectation");
        return;
      end
      want = waiting.pop_front();
      if (got.status != want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.point != want.point)
        report($sformatf("point %h, want %h", got.point, want.point));
      if (got.min_value != want.min_value)
        report($sformatf("min_value %h, want %h", got.min_value, want.min_value));
      if (got.iterations != want.iterations)
        report($sformatf("iterations %0d, want %0d", got.iterations, want.iterations));
      if (got.evaluations != want.evaluations)
        report($sformatf("evaluations %0d, want %0d", got.evaluations, want.evaluations));
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  blm_pkg::in_item_t  in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  blm_pkg::out_item_t out_item_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic               cfg_index_i;
  logic [31:0]        cfg_data_i;

  line_search_scoreboard sb;
  int            idle_mode;
  bit            hold_request;
  int unsigned   cycles;
  // test function of the running search
  int            fn_kind;
  blm_pkg::fix_t fn_center, fn_offset;

  brent_line_minimizer_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // run limit
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: check accepted beats, random stall, one long hold-off
  initial begin
    int hold_left;
    int pct;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (out_valid_o && !out_stall_i) sb.check_result(out_item_o);
        pct = (idle_mode == 0) ? 45 : (idle_mode == 1) ? 29 : 0;
        if (hold_left > 0) begin
          hold_left--;
          out_stall_i <= 1'b1;
        end else if (hold_request) begin
          hold_request = 1'b0;
          hold_left = HOLD_LEN;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= ($urandom_range(0, 99) < pct);
        end
      end
    end
  end

  // drive one input beat and wait for its acceptance, then maybe a gap
  task automatic send_beat(blm_pkg::in_item_t it);
    int pct;
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(it);
    pct = (idle_mode == 0) ? 29 : (idle_mode == 1) ? 45 : 0;
    if ($urandom_range(0, 99) < pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic launch(blm_pkg::fix_t a, blm_pkg::fix_t g, blm_pkg::fix_t b, int kind);
    blm_pkg::in_item_t it;
    it = '0;
    it.cmd = blm_pkg::CMD_START;
    it.bracket_first = a; it.initial_guess = g; it.bracket_second = b;
    it.func_value = {$urandom, $urandom};
    fn_kind = kind;
    fn_center = sb.mid_floor(a, b) + blm_pkg::fix_t'($urandom_range(0, 1 << 20))
                - (1 << 19);
    fn_offset = blm_pkg::fix_t'($urandom_range(0, 1 << 16)) - (1 << 15);
    send_beat(it);
  endtask

  task automatic feed(blm_pkg::fix_t fval);
    blm_pkg::in_item_t it;
    it = '0;
    it.cmd = blm_pkg::CMD_VALUE;
    it.bracket_first = {$urandom, $urandom};
    it.initial_guess = {$urandom, $urandom};
    it.bracket_second = {$urandom, $urandom};
    it.func_value = fval;
    send_beat(it);
  endtask

  // f at the point the block asked for
  function automatic blm_pkg::fix_t func_at(blm_pkg::fix_t u);
    blm_pkg::fix_t dx;
    if (fn_kind == 1) return fn_offset;
    if (fn_kind == 2) return {$urandom, $urandom};
    dx = sb.sub_s(u, fn_center);
    return sb.add_s(sb.fmul(dx, dx), fn_offset);
  endfunction

  function automatic blm_pkg::fix_t rand_pos();
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    return (blm_pkg::fix_t'($urandom_range(0, 1 << 16)) - (1 << 15)) <<< 20;
  endfunction

  task automatic random_launch();
    blm_pkg::fix_t a, b, g;
    int            kind, k;
    a = rand_pos();
    b = rand_pos();
    k = $urandom_range(0, 99);
    kind = (k < 70) ? 0 : (k < 85) ? 1 : 2;
    if ($urandom_range(0, 9) == 0) g = rand_pos();
    else g = sb.mid_floor(a, b) + (blm_pkg::fix_t'($urandom_range(0, 1 << 16)) <<< 8);
    launch(a, g, b, kind);
  endtask

  task automatic write_register(logic idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, data);
    cfg_valid_i <= 1'b0;
  endtask

  // stop offering beats, then wait for every expected result
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.waiting.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // short directed part
  task automatic directed_part();
    int i;
    feed(64'sd5);
    launch(-(64'sd4 <<< 32), 64'sd1 <<< 32, 64'sd4 <<< 32, 0);
    for (i = 0; i < 6 && sb.ph != blm_pkg::PH_IDLE; i++) feed(func_at(sb.pend));
    // reversed bracket and guess outside it
    launch(64'sd3 <<< 32, -(64'sd9 <<< 32), -(64'sd2 <<< 32), 0);
    for (i = 0; i < 3 && sb.ph != blm_pkg::PH_IDLE; i++) feed(func_at(sb.pend));
    // extreme bracket, extreme values
    launch(BOT_VAL, 64'sd0, TOP_VAL, 2);
    feed(TOP_VAL);
    if (sb.ph != blm_pkg::PH_IDLE) feed(BOT_VAL);
    if (sb.ph != blm_pkg::PH_IDLE) feed(64'sd0);
    // a flat function makes the parabola degenerate, so every step takes the golden section
    launch(-(64'sd1 <<< 32), 64'sd1 <<< 28, 64'sd2 <<< 32, 1);
    for (i = 0; i < 4 && sb.ph != blm_pkg::PH_IDLE; i++) feed(func_at(sb.pend));
    // restart in the middle of a search
    launch(64'sd0, 64'sd1 <<< 30, 64'sd1 <<< 32, 0);
    launch(TOP_VAL, TOP_VAL, BOT_VAL, 0);
    feed(func_at(sb.pend));
  endtask

  task automatic random_part(int count);
    int n;
    n = 0;
    while (n < count) begin
      if (sb.ph == blm_pkg::PH_IDLE) begin
        if ($urandom_range(0, 9) == 0) feed({$urandom, $urandom});
        else begin
          random_launch();
          n++;
        end
      end else if ($urandom_range(0, 99) < 4) begin
        random_launch();
        n++;
      end else begin
        feed(func_at(sb.pend));
        n++;
      end
    end
  endtask

  initial begin
    sb = new();
    idle_mode = 0;
    hold_request = 1'b0;
    fn_kind = 0; fn_center = 0; fn_offset = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = blm_pkg::CFG_TOL;
    cfg_data_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_part();
    random_part(110);
    drain();

    write_register(blm_pkg::CFG_TOL, 32'd0);
    write_register(blm_pkg::CFG_LIM, 32'd1);
    random_part(80);
    drain();

    idle_mode = 1;
    write_register(blm_pkg::CFG_TOL, 32'hFFFF_FFFF);
    write_register(blm_pkg::CFG_LIM, 32'd65535);
    hold_request = 1'b1;
    random_part(90);
    drain();

    write_register(blm_pkg::CFG_TOL, $urandom);
    write_register(blm_pkg::CFG_LIM, $urandom_range(5, 60));
    random_part(120);
    drain();

    idle_mode = 2;
    write_register(blm_pkg::CFG_TOL, 32'd1 << 22);
    write_register(blm_pkg::CFG_LIM, 32'd100);
    random_part(130);
    drain();

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/blm_pkg.sv
sv/blm_mul.sv
sv/blm_div.sv
sv/blm_dp.sv
sv/blm_ctrl.sv
sv/brent_line_minimizer_unit.sv
tb/brent_line_minimizer_unit_tb.sv
